### design/b2d_pkg.sv
`timescale 1ns / 1ps
package b2d_pkg;
    localparam int DEF_VALUE_WIDTH = 64;
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    // Number of decimal digits needed for a w-bit value: ceil(w*log10(2)).
    function automatic int max_digits(input int w);
        return (w * 30103 + 99999) / 100000;
    endfunction
endpackage

### design/b2d_dabble.sv
`timescale 1ns / 1ps
// Double-dabble stage: shift BITS_PER_STAGE binary bits into the BCD register.
module b2d_dabble
    import b2d_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int BITS_PER_STAGE = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [VALUE_WIDTH-1:0]       in_bin,
    input  logic [4*max_digits(VALUE_WIDTH)-1:0] in_bcd,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [VALUE_WIDTH-1:0]       out_bin,
    output logic [4*max_digits(VALUE_WIDTH)-1:0] out_bcd
);
    localparam int ND = max_digits(VALUE_WIDTH);

    logic                   valid_reg;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [4*ND-1:0]        bcd_reg, bcd_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        logic [4*ND-1:0] b;
        logic [VALUE_WIDTH-1:0] v;
        b = in_bcd;
        v = in_bin;
        for (int s = 0; s < BITS_PER_STAGE; s++)
        begin
            for (int d = 0; d < ND; d++)
            begin
                if (b[4*d +: 4] >= 4'd5)
                begin
                    b[4*d +: 4] = b[4*d +: 4] + 4'd3;
                end
            end
            b = {b[4*ND-2:0], v[VALUE_WIDTH-1]};
            v = {v[VALUE_WIDTH-2:0], 1'b0};
        end
        bcd_next = b;
        bin_next = v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_bin   = bin_reg;
    assign out_bcd   = bcd_reg;
endmodule

### design/b2d_serializer.sv
`timescale 1ns / 1ps
// Emit BCD digits most significant first, skipping leading zeros.
module b2d_serializer
    import b2d_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [4*max_digits(VALUE_WIDTH)-1:0] in_bcd,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [5:0]                 out_char,
    output logic                       out_last
);
    localparam int ND = max_digits(VALUE_WIDTH);
    localparam int IW = (ND > 1) ? $clog2(ND) : 1;

    logic            busy_reg;
    logic [4*ND-1:0] bcd_reg;
    logic [IW-1:0]   idx_reg;
    logic [IW-1:0]   top;
    logic            ovalid_reg;
    logic [5:0]      char_reg;
    logic            last_reg;
    logic            take;

    // Find most significant nonzero digit (one search per value).
    always_comb
    begin
        top = '0;
        for (int d = 0; d < ND; d++)
        begin
            if (in_bcd[4*d +: 4] != 4'd0)
            begin
                top = IW'(d);
            end
        end
    end

    assign in_ready = !busy_reg;
    assign take = !ovalid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                ovalid_reg <= busy_reg;
            end
            if (!busy_reg && in_valid)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && take && idx_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && in_valid)
        begin
            bcd_reg <= in_bcd;
            idx_reg <= top;
        end
        else if (busy_reg && take)
        begin
            char_reg <= ASCII_ZERO + {2'b00, bcd_reg[4*idx_reg +: 4]};
            last_reg <= (idx_reg == '0);
            idx_reg  <= idx_reg - 1'b1;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;
endmodule

### design/binary_to_decimal_digits_core.sv
`timescale 1ns / 1ps
// Binary to ASCII decimal converter. Each s_axis transaction carries one
// unsigned value (low VALUE_WIDTH bits used); the block answers with one
// m_axis transaction per decimal digit, most significant first, no leading
// zeros (zero gives a single '0'), tlast on the final digit. Conversion is a
// double-dabble pipeline of several stages, eight bits per stage, that
// accepts a value every cycle while the output is not stalled; the digit
// serializer then emits one digit per cycle while m_axis_tready is high, 1 to
// 20 digits for 64 bits, and takes a new value only once the last is done.
module binary_to_decimal_digits_core
    import b2d_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [5:0] digit_char, [7:6] zero
    output logic        m_axis_tlast
);
    localparam int BPS = 8;
    localparam int NST = (VALUE_WIDTH + BPS - 1) / BPS;
    localparam int PADW = NST * BPS;
    localparam int ND  = max_digits(PADW);

    logic [NST:0]          v;
    logic [NST:0]          r;
    logic [PADW-1:0]       bin [NST+1];
    logic [4*ND-1:0]       bcd [NST+1];
    logic [5:0]            ch;

    // Zero-extend the value to whole stages; leading zeros leave the digits unchanged.
    assign bin[0] = PADW'(s_axis_tdata[VALUE_WIDTH-1:0]);
    assign bcd[0] = '0;
    assign v[0] = s_axis_tvalid;
    assign s_axis_tready = r[0];

    for (genvar g = 0; g < NST; g++)
    begin : g_stage
        b2d_dabble #(.VALUE_WIDTH(PADW), .BITS_PER_STAGE(BPS)) u_dab (
            .clk(clk), .rst_n(rst_n),
            .in_valid(v[g]), .in_ready(r[g]),
            .in_bin(bin[g]), .in_bcd(bcd[g][4*ND-1:0]),
            .out_valid(v[g+1]), .out_ready(r[g+1]),
            .out_bin(bin[g+1]), .out_bcd(bcd[g+1])
        );
    end

    b2d_serializer #(.VALUE_WIDTH(PADW)) u_ser (
        .clk(clk), .rst_n(rst_n),
        .in_valid(v[NST]), .in_ready(r[NST]), .in_bcd(bcd[NST]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_char(ch), .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, ch};
endmodule

### test/b2d_checker.sv
`timescale 1ns / 1ps
module b2d_checker
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          digits_pending,
    output int          digits_seen
);
    typedef struct packed {
        logic [5:0] digit_char;
        logic       last;
    } digit_t;

    digit_t digit_queue[$];

    // Append the decimal digits of one value, most significant first.
    task automatic push_digits(input logic [63:0] raw);
        logic [63:0] v;
        logic [3:0]  rev[20];
        int          n;
        digit_t      d;
        v = (VALUE_WIDTH == 64) ? raw : (raw & ((64'd1 << VALUE_WIDTH) - 64'd1));
        n = 0;
        do
        begin
            rev[n] = 4'(v % 64'd10);
            v = v / 64'd10;
            n++;
        end
        while (v != 0 && n < 20);
        for (int k = 0; k < n; k++)
        begin
            d.digit_char = 6'd48 + 6'(rev[n - 1 - k]);
            d.last = (k == n - 1);
            digit_queue.push_back(d);
        end
    endtask

    assign digits_pending = digit_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        digit_t exp_d;
        if (!rst_n)
        begin
            fail_count <= 0;
            digits_seen <= 0;
            digit_queue.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                digits_seen <= digits_seen + 1;
                if (digit_queue.size() == 0)
                begin
                    $display("%0t: unexpected digit: expected none, actual %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_d = digit_queue.pop_front();
                    if (m_axis_tdata !== {2'b00, exp_d.digit_char}
                        || m_axis_tlast !== exp_d.last)
                    begin
                        $display("%0t: digit mismatch: expected %h last %b, actual %h last %b",
                                 $time, {2'b00, exp_d.digit_char}, exp_d.last,
                                 m_axis_tdata, m_axis_tlast);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                push_digits(s_axis_tdata);
        end
    end
endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    localparam int NUM_RANDOM = 316;
    localparam int CYCLE_LIMIT = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count;
    int          digits_pending;
    int          digits_seen;
    int          cycle_count = 0;
    int          values_sent = 0;
    bit          quiet_phase = 1'b0;
    bit          hold_sink = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    binary_to_decimal_digits_core DUT (.*);

    b2d_checker CHK (.*);

    // Bail out if the run hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Sink side: random stall bursts, a long hold-off on request, none at the end.
    initial
    begin
        int burst;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_sink)
                m_axis_tready <= 1'b0;
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 13);
                m_axis_tready <= 1'b0;
                repeat (burst - 1) @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Offer one value and hold it until the transaction completes.
    task automatic send_value(input logic [63:0] v);
        int burst;
        if (!quiet_phase && $urandom_range(0, 4) == 0)
        begin
            burst = $urandom_range(1, 13);
            s_axis_tvalid <= 1'b0;
            repeat (burst) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        values_sent++;
    endtask

    // Random value with a random decimal magnitude, so every digit count shows up.
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int sel;
        v = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        if (sel < 6)
            v = v >> $urandom_range(0, 63);
        else if (sel == 6)
            v = 64'd10_000_000_000_000_000_000 + (v >> 4);
        else if (sel == 7)
            v = 64'd10 ** $urandom_range(0, 19) - $urandom_range(0, 1);
        return v;
    endfunction

    initial
    begin
        logic [63:0] directed[$];
        directed = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
                     64'd1234567890, 64'd999_999_999_999_999_999,
                     64'd9_999_999_999_999_999_999, 64'd10_000_000_000_000_000_000,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                     64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                     64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                     64'd100_000, 64'd42, 64'd0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_value(directed[i]);

        // Stall the sink long enough for the pipeline to back up into the input.
        hold_sink = 1'b1;
        fork
            begin
                repeat (150) @(posedge clk);
                hold_sink = 1'b0;
            end
            repeat (25) send_value(random_value());
        join

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == NUM_RANDOM - 40)
                quiet_phase = 1'b1;
            send_value(random_value());
        end
        s_axis_tvalid <= 1'b0;

        while (digits_pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("converted %0d values into %0d digits, including zero, 20-digit values",
                 values_sent, digits_seen);
        $display("and an output stall long enough to back up the input");
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
